// File: hw/rtl/icpm_pkg.sv
// ----------------------------------------------------------------------------
// icpm_pkg
// Shared types and constants of the input capture period meter.
// ----------------------------------------------------------------------------
package icpm_pkg;

  typedef enum logic [1:0] {
    CMD_OVERFLOW = 2'd0,
    CMD_CAPTURE  = 2'd1,
    CMD_READ     = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_PERIODS_TO_AVERAGE      = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_LATE_OVERFLOW_THRESHOLD = 1'd1;

  localparam logic [15:0] PeriodsToAverageRst      = 16'd1;
  localparam logic [15:0] LateOverflowThresholdRst = 16'hFF00;
  localparam logic [31:0] EmptyReadData            = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  fill_count;
    logic        read_was_empty;
    logic        period_stored;
    logic        period_dropped;
  } rsp_t;

endpackage

// File: hw/rtl/icpm_if.sv
// ----------------------------------------------------------------------------
// icpm_req_if / icpm_rsp_if
// Valid/ready channels for requests and results of the period meter.
// ----------------------------------------------------------------------------
interface icpm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] capture_low;
  logic        overflow_pending;

  modport source (output valid, output cmd, output capture_low, output overflow_pending,
                  input ready);
  modport sink   (input valid, input cmd, input capture_low, input overflow_pending,
                  output ready);
endinterface

interface icpm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [3:0]  fill_count;
  logic        read_was_empty;
  logic        period_stored;
  logic        period_dropped;

  modport source (output valid, output read_data, output fill_count,
                  output read_was_empty, output period_stored, output period_dropped,
                  input ready);
  modport sink   (input valid, input read_data, input fill_count,
                  input read_was_empty, input period_stored, input period_dropped,
                  output ready);
endinterface

// File: hw/rtl/input_capture_period_meter_core.sv
// ----------------------------------------------------------------------------
// input_capture_period_meter_core
// Pipeline: an accepted request is registered in stage s1, then in the output
// register. Throughput: one request per cycle unless the output is stalled; the
// period store has one write and one read port with registered read data.
// Reset: clears counters, indices and reference, and loads the configuration
// defaults; store contents stay undefined until written, as only pushed entries are ever popped.
// ----------------------------------------------------------------------------
module input_capture_period_meter_core #(
  parameter int unsigned FIFO_SLOTS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [icpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [icpm_pkg::CfgDataW-1:0] cfg_data_i,
  icpm_req_if.sink                      req_i,
  icpm_rsp_if.source                    rsp_o
);

  localparam int unsigned IdxW = (FIFO_SLOTS > 1) ? $clog2(FIFO_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastSlot = IdxW'(FIFO_SLOTS - 1);
  localparam logic [IdxW:0]   Slots    = (IdxW+1)'(FIFO_SLOTS);

  logic [15:0]     pta_q, thr_q;
  logic [15:0]     upper_q, upper_d;
  logic [31:0]     ref_q, ref_d;
  logic            ref_vld_q, ref_vld_d;
  logic [15:0]     edge_q, edge_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;

  logic [31:0] mem [FIFO_SLOTS];
  logic [31:0] mem_rd_q;

  logic        s1_vld_q, s1_pop_q;
  icpm_pkg::rsp_t s1_q, s1_d;
  logic        s1_pop_d;
  logic        out_vld_q;
  icpm_pkg::rsp_t out_q;

  logic        accept, advance, push;
  logic [31:0] cap, period;
  logic [15:0] upper_cap, edge_inc;
  logic [IdxW-1:0] wr_next, rd_next;
  logic [IdxW:0]   entries;
  icpm_pkg::cmd_e cmd;

  assign advance     = !out_vld_q || rsp_o.ready;
  assign req_i.ready = !s1_vld_q || advance;
  assign accept      = req_i.valid && req_i.ready;
  assign cmd         = icpm_pkg::cmd_e'(req_i.cmd);

  assign wr_next = (wr_idx_q == LastSlot) ? '0 : wr_idx_q + IdxW'(1);
  assign rd_next = (rd_idx_q == LastSlot) ? '0 : rd_idx_q + IdxW'(1);

  always_comb begin
    upper_d   = upper_q;
    ref_d     = ref_q;
    ref_vld_d = ref_vld_q;
    edge_d    = edge_q;
    wr_idx_d  = wr_idx_q;
    rd_idx_d  = rd_idx_q;
    push      = 1'b0;
    s1_pop_d  = 1'b0;
    s1_d      = '0;
    upper_cap = (req_i.overflow_pending && (req_i.capture_low < thr_q)) ?
                upper_q + 16'd1 : upper_q;
    cap       = {upper_cap, req_i.capture_low};
    period    = cap - ref_q;
    edge_inc  = edge_q + 16'd1;
    case (cmd)
      icpm_pkg::CMD_OVERFLOW: begin
        upper_d = upper_q + 16'd1;
      end
      icpm_pkg::CMD_CAPTURE: begin
        upper_d = upper_cap;
        if (!ref_vld_q) begin
          ref_d     = cap;
          ref_vld_d = 1'b1;
        end else if (edge_inc == pta_q) begin
          ref_d  = cap;
          edge_d = '0;
          if (wr_next != rd_idx_q) begin
            push               = 1'b1;
            wr_idx_d           = wr_next;
            s1_d.period_stored = 1'b1;
          end else begin
            s1_d.period_dropped = 1'b1;
          end
        end else begin
          edge_d = edge_inc;
        end
      end
      icpm_pkg::CMD_READ: begin
        if (wr_idx_q == rd_idx_q) begin
          s1_d.read_data      = icpm_pkg::EmptyReadData;
          s1_d.read_was_empty = 1'b1;
        end else begin
          s1_pop_d = 1'b1;
          rd_idx_d = rd_next;
        end
      end
      default: begin
      end
    endcase
    entries = (wr_idx_d >= rd_idx_d) ?
              {1'b0, wr_idx_d} - {1'b0, rd_idx_d} :
              Slots + {1'b0, wr_idx_d} - {1'b0, rd_idx_d};
    s1_d.fill_count = 4'(entries);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pta_q     <= icpm_pkg::PeriodsToAverageRst;
      thr_q     <= icpm_pkg::LateOverflowThresholdRst;
      upper_q   <= '0;
      ref_q     <= '0;
      ref_vld_q <= 1'b0;
      edge_q    <= '0;
      wr_idx_q  <= '0;
      rd_idx_q  <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          icpm_pkg::REG_PERIODS_TO_AVERAGE:      pta_q <= cfg_data_i;
          icpm_pkg::REG_LATE_OVERFLOW_THRESHOLD: thr_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (accept) begin
        upper_q   <= upper_d;
        ref_q     <= ref_d;
        ref_vld_q <= ref_vld_d;
        edge_q    <= edge_d;
        wr_idx_q  <= wr_idx_d;
        rd_idx_q  <= rd_idx_d;
      end
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (advance) begin
        s1_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && push) begin
      mem[wr_idx_q] <= period;
    end
    if (accept) begin
      mem_rd_q <= mem[rd_idx_q];
      s1_q     <= s1_d;
      s1_pop_q <= s1_pop_d;
    end
    if (advance && s1_vld_q) begin
      out_q <= s1_q;
      if (s1_pop_q) begin
        out_q.read_data <= mem_rd_q;
      end
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.read_data      = out_q.read_data;
  assign rsp_o.fill_count     = out_q.fill_count;
  assign rsp_o.read_was_empty = out_q.read_was_empty;
  assign rsp_o.period_stored  = out_q.period_stored;
  assign rsp_o.period_dropped = out_q.period_dropped;

endmodule
